// ===== rtl/core/line_token_classifier_macros.svh =====
// Assertion macros for the line token classifier.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LINE_TOKEN_CLASSIFIER_MACROS_SVH
`define LINE_TOKEN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ltc_pkg.sv =====
// Shared types, class codes and the literal table of the line token classifier.
// No dependencies; used by every module of the block.
package ltc_pkg;

  localparam int LENGTH_LIMIT_DEF = 1023;

  localparam int CHAR_W    = 8;
  localparam int TYPE_W    = 6;
  localparam int LEN_W     = 10;
  localparam int NUM_CLASS = 36;
  localparam int NUM_LIT   = 29;

  // Token class indexes in table order
  localparam int CLASS_INTEGER  = 0;
  localparam int CLASS_FLOATING = 1;
  localparam int CLASS_STRING   = 2;
  localparam int CLASS_IDENT    = 3;
  localparam int LIT_BASE       = 4;
  localparam int CLASS_COMMENT  = 33;
  localparam int CLASS_SPACE    = 34;
  localparam int CLASS_NEWLINE  = 35;

  localparam logic              OP_CHAR = 1'b0;
  localparam logic              OP_END  = 1'b1;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;

  // Literal text, right-justified: the first character sits in the highest used byte
  localparam logic [63:0] LIT_TEXT [NUM_LIT] = '{
    "+", "-", "*", "/", "=", "==", "!=",
    "if", "else", "while", "for", "function", "return", "true", "false", "empty",
    "(", ")", "{", "}", "[", "]", ",", ";", ":",
    "<", "<=", ">", ">="
  };

  localparam logic [3:0] LIT_LEN [NUM_LIT] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2,
    4'd2, 4'd4, 4'd5, 4'd3, 4'd8, 4'd6, 4'd4, 4'd5, 4'd5,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd2, 4'd1, 4'd2
  };

  // Expected character of literal idx at position pos (zero past its end)
  function automatic logic [CHAR_W-1:0] lit_byte(input int idx, input logic [2:0] pos);
    logic [63:0] txt;
    int          len;
    begin
      txt      = LIT_TEXT[idx];
      len      = int'(LIT_LEN[idx]);
      lit_byte = '0;
      if (int'(pos) < len) begin
        lit_byte = txt[8*(len-1-int'(pos)) +: 8];
      end
    end
  endfunction

  // State of the recognizers as seen at the end of a line
  typedef struct packed {
    logic                 nonempty;
    logic [NUM_CLASS-1:0] match;
    logic [LEN_W-1:0]     length;
  } line_sum_t;

  // Up to two classes picked for one line
  typedef struct packed {
    logic [1:0]        n;
    logic [TYPE_W-1:0] type0;
    logic [TYPE_W-1:0] type1;
    logic [LEN_W-1:0]  length;
  } pick_t;

endpackage

// ===== rtl/core/ltc_scan.sv =====
// Per-character recognizers of the line token classifier: all classes advance in parallel.
// Depends on ltc_pkg.
module ltc_scan #(
  parameter int LENGTH_LIMIT = ltc_pkg::LENGTH_LIMIT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take_char,
  input  logic                      end_line,
  input  logic [ltc_pkg::CHAR_W-1:0] char_code,
  output ltc_pkg::line_sum_t        sum
);
  import ltc_pkg::*;

  localparam int CW = $clog2(LENGTH_LIMIT + 1);

  localparam logic [2:0] NP_START = 3'd0;
  localparam logic [2:0] NP_INT   = 3'd1;
  localparam logic [2:0] NP_DOT   = 3'd2;
  localparam logic [2:0] NP_FRAC  = 3'd3;
  localparam logic [2:0] NP_DEAD  = 3'd4;

  localparam logic [1:0] SP_START  = 2'd0;
  localparam logic [1:0] SP_BODY   = 2'd1;
  localparam logic [1:0] SP_CLOSED = 2'd2;
  localparam logic [1:0] SP_DEAD   = 2'd3;

  localparam logic [1:0] CP_START = 2'd0;
  localparam logic [1:0] CP_SLASH = 2'd1;
  localparam logic [1:0] CP_BODY  = 2'd2;
  localparam logic [1:0] CP_DEAD  = 2'd3;

  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SP    = 8'h20;

  logic [CW-1:0]      count_r, count_nxt;
  logic [NUM_LIT-1:0] alive_r, alive_nxt;
  logic [2:0]         np_r, np_nxt;
  logic [1:0]         sp_r, sp_nxt;
  logic               ident_r, ident_nxt;
  logic [1:0]         cp_r, cp_nxt;
  logic               space_r, space_nxt;

  logic               is_digit, is_alpha, is_space, pos_short;
  logic [2:0]         pos;
  logic [CW+LEN_W-1:0] count_ext;

  assign is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_alpha  = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                     ((char_code >= 8'h41) && (char_code <= 8'h5A)) || (char_code == 8'h5F);
  assign is_space  = (char_code == CH_SP) || ((char_code >= 8'h09) && (char_code <= CH_CR));
  assign pos       = count_r[2:0];
  assign pos_short = (count_r[CW-1:3] == '0);

  always_comb begin
    for (int i = 0; i < NUM_LIT; i++) begin
      alive_nxt[i] = alive_r[i] && pos_short && ({1'b0, pos} < LIT_LEN[i]) &&
                     (char_code == lit_byte(i, pos));
    end

    case (np_r)
      NP_START: np_nxt = is_digit ? NP_INT : NP_DEAD;
      NP_INT:   np_nxt = is_digit ? NP_INT : ((char_code == CH_DOT) ? NP_DOT : NP_DEAD);
      NP_DOT,
      NP_FRAC:  np_nxt = is_digit ? NP_FRAC : NP_DEAD;
      default:  np_nxt = NP_DEAD;
    endcase

    case (sp_r)
      SP_START: sp_nxt = (char_code == CH_QUOTE) ? SP_BODY : SP_DEAD;
      SP_DEAD:  sp_nxt = SP_DEAD;
      default: begin
        if (char_code == CH_CR || char_code == CHAR_LF) begin
          sp_nxt = SP_DEAD;
        end else if (char_code == CH_QUOTE) begin
          sp_nxt = SP_CLOSED;
        end else begin
          sp_nxt = SP_BODY;
        end
      end
    endcase

    if (count_r == '0) begin
      ident_nxt = is_alpha;
    end else begin
      ident_nxt = ident_r && (is_alpha || is_digit);
    end

    case (cp_r)
      CP_START: cp_nxt = (char_code == CH_SLASH) ? CP_SLASH : CP_DEAD;
      CP_SLASH: cp_nxt = (char_code == CH_SLASH) ? CP_BODY : CP_DEAD;
      CP_BODY:  cp_nxt = (char_code == CH_CR || char_code == CHAR_LF) ? CP_DEAD : CP_BODY;
      default:  cp_nxt = CP_DEAD;
    endcase

    space_nxt = space_r && is_space;

    // Saturate the length at the limit
    if (count_r < CW'(LENGTH_LIMIT)) begin
      count_nxt = count_r + CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || end_line) begin
      count_r <= '0;
      alive_r <= '1;
      np_r    <= NP_START;
      sp_r    <= SP_START;
      ident_r <= 1'b1;
      cp_r    <= CP_START;
      space_r <= 1'b1;
    end else if (take_char) begin
      count_r <= count_nxt;
      alive_r <= alive_nxt;
      np_r    <= np_nxt;
      sp_r    <= sp_nxt;
      ident_r <= ident_nxt;
      cp_r    <= cp_nxt;
      space_r <= space_nxt;
    end
  end

  assign count_ext = {{LEN_W{1'b0}}, count_r};

  always_comb begin
    sum.nonempty = (count_r != '0);
    sum.length   = count_ext[LEN_W-1:0];
    sum.match    = '0;
    sum.match[CLASS_INTEGER]  = (np_r == NP_INT);
    sum.match[CLASS_FLOATING] = (np_r == NP_FRAC);
    sum.match[CLASS_STRING]   = (sp_r == SP_CLOSED);
    sum.match[CLASS_IDENT]    = ident_r;
    for (int i = 0; i < NUM_LIT; i++) begin
      sum.match[LIT_BASE+i] = alive_r[i] && (count_r == CW'(LIT_LEN[i]));
    end
    sum.match[CLASS_COMMENT]  = (cp_r == CP_BODY);
    sum.match[CLASS_SPACE]    = space_r;
    // A line never holds a newline, so that class stays clear
    sum.match[CLASS_NEWLINE]  = 1'b0;
    if (!sum.nonempty) begin
      sum.match = '0;
    end
  end

endmodule

// ===== rtl/core/ltc_select.sv =====
// Picks the first two matching classes of a finished line in table order.
// Depends on ltc_pkg.
module ltc_select (
  input  ltc_pkg::line_sum_t sum,
  output ltc_pkg::pick_t     pick
);
  import ltc_pkg::*;

  logic [NUM_CLASS-1:0] rest;
  logic [TYPE_W-1:0]    first, second;

  always_comb begin
    first = '0;
    for (int i = NUM_CLASS - 1; i >= 0; i--) begin
      if (sum.match[i]) begin
        first = TYPE_W'(i);
      end
    end
    // Drop the first hit, then search again for the second
    rest = sum.match & ~({{(NUM_CLASS-1){1'b0}}, 1'b1} << first);
    second = '0;
    for (int i = NUM_CLASS - 1; i >= 0; i--) begin
      if (rest[i]) begin
        second = TYPE_W'(i);
      end
    end

    pick.type0  = first;
    pick.type1  = second;
    pick.length = sum.length;
    if (rest != '0) begin
      pick.n = 2'd2;
    end else if (sum.match != '0) begin
      pick.n = 2'd1;
    end else begin
      pick.n = 2'd0;
    end
  end

endmodule

// ===== rtl/core/ltc_out.sv =====
// Two-slot line token classifier result register; drains one item per ready cycle.
// Depends on ltc_pkg.
module ltc_out (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  ltc_pkg::pick_t             pick,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [ltc_pkg::TYPE_W-1:0] token_type,
  output logic [ltc_pkg::LEN_W-1:0]  line_length,
  output logic                       last_of_line,
  output logic                       free
);
  import ltc_pkg::*;

  logic [1:0]        cnt_r;
  logic [TYPE_W-1:0] type0_r, type1_r;
  logic [LEN_W-1:0]  len_r;
  logic              pop;

  assign out_tvalid   = (cnt_r != 2'd0);
  assign pop          = out_tvalid && out_tready;
  assign token_type   = type0_r;
  assign line_length  = len_r;
  assign last_of_line = (cnt_r == 2'd1);
  // Room for a new line when the buffer is empty or its last item leaves now
  assign free         = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= pick.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      type0_r <= pick.type0;
      type1_r <= pick.type1;
      len_r   <= pick.length;
    end else if (pop && (cnt_r == 2'd2)) begin
      type0_r <= type1_r;
    end
  end

endmodule

// ===== rtl/core/line_token_classifier.sv =====
// Line token classifier: one result per class matched by a whole line, at most two per line.
// Latency: results of a line appear the cycle after its newline or end item is accepted.
// Throughput: one item per cycle; the input stalls only while results held back by the
// receiver leave no room in the two-slot result register for a line that already matches.
// Reset: synchronous, active-low rst_n clears the recognizers, line length and result slots.
module line_token_classifier #(
  parameter int LENGTH_LIMIT = ltc_pkg::LENGTH_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [5:0] token_type, [15:6] line_length
  output logic        out_tlast   // last_of_line
);
  import ltc_pkg::*;

  `include "line_token_classifier_macros.svh"

  logic              in_fire, is_eol, take_char, end_line, load, out_free;
  line_sum_t         sum;
  pick_t             pick;
  logic [TYPE_W-1:0] token_type;
  logic [LEN_W-1:0]  line_length;

  assign in_fire   = in_tvalid && in_tready;
  assign is_eol    = (in_tuser == OP_END) || (in_tdata == CHAR_LF);
  assign take_char = in_fire && !is_eol;
  assign end_line  = in_fire && is_eol;
  assign load      = end_line && (pick.n != 2'd0);
  // A line with no match so far cannot load on this item, so take it while results wait
  assign in_tready = out_free || (pick.n == 2'd0);

  ltc_scan #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take_char (take_char),
    .end_line  (end_line),
    .char_code (in_tdata),
    .sum       (sum)
  );

  ltc_select u_select (
    .sum  (sum),
    .pick (pick)
  );

  ltc_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .pick         (pick),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .token_type   (token_type),
    .line_length  (line_length),
    .last_of_line (out_tlast),
    .free         (out_free)
  );

  assign out_tdata = {line_length, token_type};

  `LTC_ASSERT_NEXT(a_line_gives_result, load, out_tvalid, "matched line produced no result")
  `LTC_ASSERT_NOW(a_load_when_free, load, !out_tvalid || (out_tlast && out_tready), "overwrite")
  `LTC_ASSERT_NOW(a_no_newline_class, out_tvalid, token_type != TYPE_W'(CLASS_NEWLINE), "newline")
  `LTC_ASSERT_NEXT(a_char_counts, take_char, sum.nonempty, "character left the line empty")

endmodule

// ===== bench/tb_line_token_classifier.sv =====
// Self-checking bench for line_token_classifier: streams character lines and checks each token.
// Depends on ltc_pkg for widths, class codes and operation codes; needs only the RTL.
module tb_line_token_classifier;
  import ltc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 400;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;

  typedef struct {
    logic [TYPE_W-1:0] tok_class;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  typedef enum logic [2:0] {NUM_START, NUM_INT, NUM_DOT, NUM_FRAC, NUM_DEAD} num_phase_e;
  typedef enum logic [1:0] {STR_START, STR_BODY, STR_CLOSED, STR_DEAD} str_phase_e;
  typedef enum logic [1:0] {REM_START, REM_SLASH, REM_BODY, REM_DEAD} rem_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = OP_CHAR;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  // Predicted line state
  int                   line_chars;
  logic [NUM_LIT-1:0]   lit_live;
  num_phase_e           num_ph;
  str_phase_e           str_ph;
  logic                 ident_live;
  rem_phase_e           rem_ph;
  logic                 blank_live;

  token_t               token_q[$];
  logic [CHAR_W-1:0]    line_buf[$];
  int                   errors = 0;
  int                   sent_items = 0;
  int                   burst_left = 0;
  int                   cycles = 0;
  int                   hold_left = 0;
  logic [15:0]          ready_pat = 16'hFFFF;
  int                   pat_age = 0;

  line_token_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: rotating stall pattern, overridden by a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ready_pat[0];
      if (pat_age == 63) begin
        ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'($urandom);
        pat_age <= 0;
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
        pat_age <= pat_age + 1;
      end
    end
  end

  // Sample at the falling edge; the handshake completes at the next rising edge
  always @(negedge clk) begin
    token_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token, class %0d length %0d last %0b", $time,
                 out_tdata[TYPE_W-1:0], out_tdata[TYPE_W +: LEN_W], out_tlast);
        errors++;
      end else begin
        want = token_q.pop_front();
        if (out_tdata[TYPE_W-1:0] !== want.tok_class) begin
          $display("%0t: token_type expected %0d, got %0d", $time, want.tok_class,
                   out_tdata[TYPE_W-1:0]);
          errors++;
        end
        if (out_tdata[TYPE_W +: LEN_W] !== want.len) begin
          $display("%0t: line_length expected %0d, got %0d", $time, want.len,
                   out_tdata[TYPE_W +: LEN_W]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last_of_line expected %0b, got %0b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  function automatic string lit_spelling(input int idx);
    case (idx)
      0: return "+";         1: return "-";       2: return "*";       3: return "/";
      4: return "=";         5: return "==";      6: return "!=";      7: return "if";
      8: return "else";      9: return "while";   10: return "for";    11: return "function";
      12: return "return";   13: return "true";   14: return "false";  15: return "empty";
      16: return "(";        17: return ")";      18: return "{";      19: return "}";
      20: return "[";        21: return "]";      22: return ",";      23: return ";";
      24: return ":";        25: return "<";      26: return "<=";     27: return ">";
      default: return ">=";
    endcase
  endfunction

  // Append one byte to the line being built
  function automatic void put_byte(input logic [CHAR_W-1:0] b);
    line_buf.insert(line_buf.size(), b);
  endfunction

  function automatic void reset_line();
    line_chars = 0;
    lit_live   = '1;
    num_ph     = NUM_START;
    str_ph     = STR_START;
    ident_live = 1'b1;
    rem_ph     = REM_START;
    blank_live = 1'b1;
  endfunction

  function automatic void advance_line(input logic [CHAR_W-1:0] c);
    string s;
    logic  dig;
    logic  word;
    dig  = (c >= "0" && c <= "9");
    word = dig || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    for (int i = 0; i < NUM_LIT; i++) begin
      s = lit_spelling(i);
      if (line_chars >= s.len() || s[line_chars] != c) lit_live[i] = 1'b0;
    end
    case (num_ph)
      NUM_START:      num_ph = dig ? NUM_INT : NUM_DEAD;
      NUM_INT:        num_ph = dig ? NUM_INT : ((c == ".") ? NUM_DOT : NUM_DEAD);
      NUM_DOT, NUM_FRAC: num_ph = dig ? NUM_FRAC : NUM_DEAD;
      default:        num_ph = NUM_DEAD;
    endcase
    if (str_ph == STR_START) begin
      str_ph = (c == "\"") ? STR_BODY : STR_DEAD;
    end else if (str_ph != STR_DEAD) begin
      str_ph = (c == CH_CR || c == CHAR_LF) ? STR_DEAD : ((c == "\"") ? STR_CLOSED : STR_BODY);
    end
    if (line_chars == 0) ident_live = word && !dig;
    else if (!word) ident_live = 1'b0;
    if (rem_ph == REM_START) rem_ph = (c == "/") ? REM_SLASH : REM_DEAD;
    else if (rem_ph == REM_SLASH) rem_ph = (c == "/") ? REM_BODY : REM_DEAD;
    else if (rem_ph == REM_BODY && (c == CH_CR || c == CHAR_LF)) rem_ph = REM_DEAD;
    if (!(c == " " || (c >= 8'h09 && c <= 8'h0D))) blank_live = 1'b0;
    if (line_chars < LENGTH_LIMIT_DEF) line_chars++;
  endfunction

  function automatic void close_line();
    logic [TYPE_W-1:0] picks[$];
    token_t            t;
    string             s;
    int                n;
    if (line_chars > 0) begin
      if (num_ph == NUM_INT) picks.insert(picks.size(), TYPE_W'(CLASS_INTEGER));
      if (num_ph == NUM_FRAC) picks.insert(picks.size(), TYPE_W'(CLASS_FLOATING));
      if (str_ph == STR_CLOSED) picks.insert(picks.size(), TYPE_W'(CLASS_STRING));
      if (ident_live) picks.insert(picks.size(), TYPE_W'(CLASS_IDENT));
      for (int i = 0; i < NUM_LIT; i++) begin
        s = lit_spelling(i);
        if (lit_live[i] && line_chars == s.len()) begin
          picks.insert(picks.size(), TYPE_W'(LIT_BASE + i));
        end
      end
      if (rem_ph == REM_BODY) picks.insert(picks.size(), TYPE_W'(CLASS_COMMENT));
      if (blank_live) picks.insert(picks.size(), TYPE_W'(CLASS_SPACE));
    end
    // only the first two matches in table order are reported
    n = (picks.size() > 2) ? 2 : picks.size();
    for (int k = 0; k < n; k++) begin
      t.tok_class = picks[k];
      t.len       = LEN_W'(line_chars);
      t.last      = (k == n - 1);
      token_q.insert(token_q.size(), t);
    end
    reset_line();
  endfunction

  // Drive one item in bursts with random gaps; predict once it is accepted
  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    burst_left--;
    sent_items++;
    if (op == OP_CHAR && ch != CHAR_LF) advance_line(ch);
    else close_line();
  endtask

  task automatic end_line(input bit by_end);
    if (by_end) send_item(OP_END, 8'($urandom));
    else send_item(OP_CHAR, CHAR_LF);
  endtask

  task automatic send_text(input string s, input bit by_end);
    for (int k = 0; k < s.len(); k++) send_item(OP_CHAR, s[k]);
    end_line(by_end);
  endtask

  // Pause the sender until every predicted token has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (token_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] ident_char(input bit first);
    int r;
    r = first ? $urandom_range(10, 62) : $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    if (r < 62) return 8'("A" + r - 36);
    return "_";
  endfunction

  function automatic logic [CHAR_W-1:0] body_byte(input bit allow_cr);
    logic [CHAR_W-1:0] b;
    do b = 8'($urandom); while (b == CHAR_LF || (!allow_cr && b == CH_CR));
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  // Mostly well-formed tokens with random content, some broken, some noise
  task automatic build_line();
    int    kind;
    int    n;
    string s;
    line_buf.delete();
    kind = $urandom_range(0, 17);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(digit_char());
      end
      2, 3: begin
        n = $urandom_range(1, 4);
        repeat (n) put_byte(digit_char());
        put_byte(".");
        n = $urandom_range(1, 4);
        repeat (n) put_byte(digit_char());
      end
      4, 5: begin
        put_byte("\"");
        n = $urandom_range(0, 6);
        repeat (n) put_byte(body_byte(1'b1));
        put_byte("\"");
      end
      6, 7, 8: begin
        put_byte(ident_char(1'b1));
        n = $urandom_range(0, 7);
        repeat (n) put_byte(ident_char(1'b0));
      end
      9, 10, 11, 12: begin
        s = lit_spelling($urandom_range(0, NUM_LIT - 1));
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
      end
      13, 14: begin
        put_byte("/");
        put_byte("/");
        n = $urandom_range(0, 8);
        repeat (n) put_byte(body_byte(1'b1));
      end
      15: begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: put_byte(" ");
            1: put_byte(8'h09);
            2: put_byte(8'h0B);
            3: put_byte(8'h0C);
            default: put_byte(CH_CR);
          endcase
        end
      end
      16: ;
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(8'($urandom));
      end
    endcase
    if (kind <= 15 && $urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
        1: void'(line_buf.pop_back());
        default: put_byte(8'($urandom));
      endcase
    end
  endtask

  // Extremes of the fields, both operations and the corner cases of line handling
  task automatic test_directed();
    send_item(OP_CHAR, CHAR_LF);              // empty line yields nothing
    send_text("if", 1'b0);                    // identifier and keyword
    send_text("3.5", 1'b0);
    send_item(OP_CHAR, "\"");                 // high byte inside a string
    send_item(OP_CHAR, 8'hFF);
    send_item(OP_CHAR, "\"");
    send_item(OP_CHAR, CHAR_LF);
    send_item(OP_CHAR, "/");                  // comment closed by end of input
    send_item(OP_CHAR, "/");
    send_item(OP_CHAR, 8'h80);
    send_item(OP_END, 8'hFF);
    send_item(OP_END, CHAR_LF);               // end of input on an empty line
    send_item(OP_CHAR, 8'h00);                // unmatched line
    send_item(OP_CHAR, CHAR_LF);
    send_item(OP_CHAR, " ");
    send_item(OP_CHAR, 8'h09);
    send_item(OP_CHAR, CH_CR);
    send_item(OP_END, 8'h00);
    send_text("7", 1'b0);
  endtask

  // A line past the length limit: length saturates, classification stays exact
  task automatic test_long_lines();
    send_item(OP_CHAR, ident_char(1'b1));
    for (int k = 1; k < 1030; k++) send_item(OP_CHAR, ident_char(1'b0));
    send_item(OP_END, 8'($urandom));
  endtask

  // Hold the receiver off while the sender keeps going, so the block backs up
  task automatic test_backpressure();
    hold_left = 400;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) send_text("while", 1'b0);
      else send_text("x", 1'b0);
    end
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      build_line();
      foreach (line_buf[k]) send_item(OP_CHAR, line_buf[k]);
      end_line($urandom_range(0, 6) == 0);
    end
  endtask

  initial begin
    reset_line();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_long_lines();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
